[rtl/core/erld_pkg.sv]
package erld_pkg;

    // Escape codes and the fixed length of the short zero run.
    localparam logic [7:0] ESC_ZEROS    = 8'hFD;
    localparam logic [7:0] ESC_LONG     = 8'hFE;
    localparam logic [7:0] ZERO_RUN_LEN = 8'd3;

    // Role of one packet byte, decided by the front end.
    typedef enum logic [2:0] {
        KIND_LIT   = 3'd0,
        KIND_ZEROS = 3'd1,
        KIND_LONG  = 3'd2,
        KIND_COUNT = 3'd3,
        KIND_FILL  = 3'd4
    } erld_kind_t;

    // Classified byte as it travels through the queue.
    typedef struct packed {
        erld_kind_t  kind;
        logic [7:0]  data_byte;
        logic        last;
        logic        first;
        logic [15:0] limit;
    } erld_token_t;

endpackage

[rtl/core/escape_run_length_decoder_top.sv]
// Escape-byte run-length decoder. It takes one compressed packet byte per
// cycle while the queue has room and gives at most one run descriptor
// (value, length) per byte. A byte is classified in the front end, waits
// in a queue of QUEUE_DEPTH entries, and is applied to the packet budget
// in the back end, which registers the result; a descriptor follows its
// byte through a queue slot and the result register. The queue lets the
// input keep flowing for QUEUE_DEPTH bytes while the result port is held
// off. The budget is sampled on each packet's first byte.
module escape_run_length_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_packet_end,
    input  logic [15:0] s_output_limit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_run_value,
    output logic [7:0]  m_run_length,
    output logic        m_packet_done,
    output logic        m_status,
    output logic [15:0] m_total_length
);
    import erld_pkg::*;

    erld_token_t front_tok, back_tok;
    logic        front_valid, front_ready;
    logic        back_valid, back_ready;

    // Classification of incoming bytes.
    erld_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_packet_end  (s_packet_end),
        .s_output_limit(s_output_limit),
        .tok_valid     (front_valid),
        .tok_ready     (front_ready),
        .tok           (front_tok)
    );

    // Decoupling queue between the two halves.
    erld_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(front_valid),
        .push_ready(front_ready),
        .push_tok  (front_tok),
        .pop_valid (back_valid),
        .pop_ready (back_ready),
        .pop_tok   (back_tok)
    );

    // Budget tracking and result generation.
    erld_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tok_valid     (back_valid),
        .tok_ready     (back_ready),
        .tok           (back_tok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_run_value   (m_run_value),
        .m_run_length  (m_run_length),
        .m_packet_done (m_packet_done),
        .m_status      (m_status),
        .m_total_length(m_total_length)
    );

endmodule

[rtl/core/erld_front.sv]
module erld_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_packet_end,
    input  logic [15:0]          s_output_limit,
    output logic                 tok_valid,
    input  logic                 tok_ready,
    output erld_pkg::erld_token_t tok
);
    import erld_pkg::*;

    // Position inside a long escape.
    typedef enum logic [2:0] {
        PH_BASE  = 3'b001,
        PH_COUNT = 3'b010,
        PH_FILL  = 3'b100
    } erld_phase_t;

    erld_phase_t phase_reg, phase_next, phase_eff;
    logic        first_reg, first_next;
    logic        xfer;
    erld_kind_t  kind;

    assign s_ready   = tok_ready;
    assign tok_valid = s_valid;
    assign xfer      = s_valid && tok_ready;

    // The first byte of a packet always starts from the base phase.
    assign phase_eff = first_reg ? PH_BASE : phase_reg;

    // Classify the byte and advance the escape phase.
    always_comb begin
        kind       = KIND_LIT;
        phase_next = PH_BASE;
        case (phase_eff)
            PH_COUNT: begin
                kind       = KIND_COUNT;
                phase_next = PH_FILL;
            end
            PH_FILL: begin
                kind       = KIND_FILL;
                phase_next = PH_BASE;
            end
            default: begin
                if (s_data_byte == ESC_ZEROS) begin
                    kind = KIND_ZEROS;
                end else if (s_data_byte == ESC_LONG) begin
                    kind       = KIND_LONG;
                    phase_next = PH_COUNT;
                end else begin
                    kind = KIND_LIT;
                end
            end
        endcase
        if (s_packet_end) begin
            phase_next = PH_BASE;
        end
        first_next = s_packet_end;
    end

    assign tok.kind      = kind;
    assign tok.data_byte = s_data_byte;
    assign tok.last      = s_packet_end;
    assign tok.first     = first_reg;
    assign tok.limit     = s_output_limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_BASE;
            first_reg <= 1'b1;
        end else if (xfer) begin
            phase_reg <= phase_next;
            first_reg <= first_next;
        end
    end

endmodule

[rtl/core/erld_queue.sv]
module erld_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  erld_pkg::erld_token_t push_tok,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output erld_pkg::erld_token_t pop_tok
);
    import erld_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    erld_token_t         slot_reg [DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_tok    = slot_reg[rd_ptr_reg];

    // Pointer and fill-count bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots need no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

[rtl/core/erld_back.sv]
module erld_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tok_valid,
    output logic                  tok_ready,
    input  erld_pkg::erld_token_t tok,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_run_value,
    output logic [7:0]            m_run_length,
    output logic                  m_packet_done,
    output logic                  m_status,
    output logic [15:0]           m_total_length
);
    import erld_pkg::*;

    logic [15:0] budget_reg, budget_next, budget_eff;
    logic [15:0] bytes_reg, bytes_next, bytes_eff;
    logic [7:0]  count_reg, count_next, count_eff;
    logic        stopped_reg, stopped_next, stopped_eff;
    logic        m_valid_reg;
    logic [7:0]  value_reg, length_reg;
    logic        done_reg, status_reg;
    logic [15:0] total_reg;

    logic        pop, have, emit, status;
    logic [7:0]  want, len, val;

    assign tok_ready = !m_valid_reg || m_ready;
    assign pop       = tok_valid && tok_ready;

    // A packet's first byte takes the run state afresh from its budget.
    assign budget_eff  = tok.first ? tok.limit : budget_reg;
    assign bytes_eff   = tok.first ? 16'd0 : bytes_reg;
    assign count_eff   = tok.first ? 8'd0 : count_reg;
    assign stopped_eff = tok.first ? (tok.limit == 16'd0) : stopped_reg;

    // Carry out one classified byte against the remaining budget.
    always_comb begin
        want       = 8'd0;
        have       = 1'b0;
        status     = 1'b0;
        val        = 8'd0;
        count_next = count_eff;
        if (!stopped_eff) begin
            case (tok.kind)
                KIND_COUNT: begin
                    count_next = tok.data_byte;
                    status     = tok.last;
                end
                KIND_FILL: begin
                    want = count_eff;
                    val  = tok.data_byte;
                    have = 1'b1;
                end
                KIND_ZEROS: begin
                    want = ZERO_RUN_LEN;
                    have = 1'b1;
                end
                KIND_LONG: begin
                    status = tok.last;
                end
                KIND_LIT: begin
                    want = 8'd1;
                    val  = tok.data_byte;
                    have = 1'b1;
                end
                default: begin
                    have = 1'b0;
                end
            endcase
        end
        len = ({8'd0, want} < budget_eff) ? want : budget_eff[7:0];
        if (len == 8'd0) begin
            val = 8'd0;
        end
        budget_next  = budget_eff;
        bytes_next   = bytes_eff;
        stopped_next = stopped_eff;
        if (have) begin
            budget_next  = budget_eff - {8'd0, len};
            bytes_next   = bytes_eff + {8'd0, len};
            stopped_next = (budget_next == 16'd0);
        end
        emit = tok.last || (have && (len != 8'd0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg  <= '0;
            bytes_reg   <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                budget_reg  <= budget_next;
                bytes_reg   <= bytes_next;
                count_reg   <= count_next;
                stopped_reg <= stopped_next;
            end
            if (pop && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result register, loaded when a descriptor is produced.
    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            value_reg  <= val;
            length_reg <= len;
            done_reg   <= tok.last;
            status_reg <= status;
            total_reg  <= bytes_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_run_value    = value_reg;
    assign m_run_length   = length_reg;
    assign m_packet_done  = done_reg;
    assign m_status       = status_reg;
    assign m_total_length = total_reg;

endmodule

[rtl/core/erld_checker.sv]
module erld_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_data_byte,
    input logic        s_packet_end,
    input logic [15:0] s_output_limit,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_run_value,
    input logic [7:0]  m_run_length,
    input logic        m_packet_done,
    input logic        m_status,
    input logic [15:0] m_total_length
);

    // A stalled result transfer keeps its descriptor.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_run_value)
            && $stable(m_run_length) && $stable(m_total_length)
            && $stable(m_packet_done) && $stable(m_status))
        else $error("result changed while stalled");

    // An empty run always carries value zero.
    a_empty_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_run_length == 8'd0) |-> (m_run_value == 8'd0))
        else $error("empty run with nonzero value");

    // A truncated escape is reported only at packet end, with no data.
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_packet_done && (m_run_length == 8'd0))
        else $error("error status outside packet end");

    // Mid-packet results always carry data.
    a_mid_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_packet_done |-> (m_run_length != 8'd0))
        else $error("empty run before packet end");

endmodule

bind escape_run_length_decoder_top erld_checker u_erld_checker (.*);

[test/erld_stream_checker.sv]
`timescale 1ns / 1ps

module erld_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_packet_end,
    input  logic [15:0] s_output_limit,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_run_value,
    input  logic [7:0]  m_run_length,
    input  logic        m_packet_done,
    input  logic        m_status,
    input  logic [15:0] m_total_length,
    output int          mismatches,
    output int          runs_outstanding
);
    import erld_pkg::*;

    typedef enum logic [2:0] {
        AWAIT_CODE  = 3'b001,
        AWAIT_COUNT = 3'b010,
        AWAIT_FILL  = 3'b100
    } decode_phase_t;

    typedef struct packed {
        logic [7:0]  value;
        logic [7:0]  length;
        logic        done;
        logic        status;
        logic [15:0] total;
    } run_desc_t;

    // Shadow copy of the decoder state.
    decode_phase_t phase;
    logic [7:0]    held_count;
    logic [15:0]   budget;
    logic [15:0]   produced;
    logic          at_packet_start;
    logic          halted;

    run_desc_t expected_runs[$];
    int        fault_total;

    // A run may not exceed what is left of the packet budget.
    function automatic logic [7:0] clip_run(input logic [7:0] want);
        return (16'(want) < budget) ? want : budget[7:0];
    endfunction

    // Decode one transferred byte and queue the descriptor it causes, if any.
    task automatic decode_byte(input logic [7:0] b, input logic last, input logic [15:0] limit);
        logic [7:0] len;
        logic [7:0] val;
        logic       truncated;
        logic       emit;
        run_desc_t  run;
        len       = '0;
        val       = '0;
        truncated = 1'b0;
        emit      = 1'b0;

        // The first byte of a packet takes the budget afresh.
        if (at_packet_start) begin
            budget          = limit;
            produced        = '0;
            phase           = AWAIT_CODE;
            held_count      = '0;
            halted          = (limit == 16'd0);
            at_packet_start = 1'b0;
        end

        if (!halted) begin
            case (phase)
                AWAIT_COUNT: begin
                    held_count = b;
                    phase      = AWAIT_FILL;
                    truncated  = last;
                end
                AWAIT_FILL: begin
                    len   = clip_run(held_count);
                    val   = b;
                    emit  = 1'b1;
                    phase = AWAIT_CODE;
                end
                default: begin
                    phase = AWAIT_CODE;
                    if (b == ESC_ZEROS) begin
                        len  = clip_run(ZERO_RUN_LEN);
                        val  = '0;
                        emit = 1'b1;
                    end else if (b == ESC_LONG) begin
                        phase     = AWAIT_COUNT;
                        truncated = last;
                    end else begin
                        len  = 8'd1;
                        val  = b;
                        emit = 1'b1;
                    end
                end
            endcase
            if (emit) begin
                budget   = budget - 16'(len);
                produced = produced + 16'(len);
                if (budget == 16'd0) halted = 1'b1;
            end
        end

        if (len == 8'd0) val = '0;

        // Empty runs are dropped unless they close the packet.
        if (last || len != 8'd0) begin
            run.value  = val;
            run.length = len;
            run.done   = last;
            run.status = truncated;
            run.total  = produced;
            expected_runs.push_back(run);
        end

        if (last) begin
            at_packet_start = 1'b1;
            phase           = AWAIT_CODE;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            fault_total++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare each result transfer first, then predict from the input transfer.
    always @(posedge aclk) begin
        run_desc_t want;
        if (!aresetn) begin
            phase           = AWAIT_CODE;
            held_count      = '0;
            budget          = '0;
            produced        = '0;
            at_packet_start = 1'b1;
            halted          = 1'b0;
            expected_runs.delete();
            fault_total     = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_runs.size() == 0) begin
                    fault_total++;
                    $display("%0t: unexpected result: expected none, %s %0h %0d %0b %0b %0d",
                             $time, "actual value/length/done/status/total =",
                             m_run_value, m_run_length, m_packet_done, m_status,
                             m_total_length);
                end else begin
                    want = expected_runs.pop_front();
                    check_field("run_value", 16'(want.value), 16'(m_run_value));
                    check_field("run_length", 16'(want.length), 16'(m_run_length));
                    check_field("packet_done", 16'(want.done), 16'(m_packet_done));
                    check_field("status", 16'(want.status), 16'(m_status));
                    check_field("total_length", want.total, m_total_length);
                end
            end
            if (s_valid && s_ready)
                decode_byte(s_data_byte, s_packet_end, s_output_limit);
        end
        mismatches       <= fault_total;
        runs_outstanding <= expected_runs.size();
    end

endmodule

[test/tb_escape_run_length_decoder_top.sv]
`timescale 1ns / 1ps

module tb_escape_run_length_decoder_top;
    import erld_pkg::*;

    localparam int BYTE_TARGET  = 1400;
    localparam int QUIET_START  = 1250;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte    = '0;
    logic        s_packet_end   = 1'b0;
    logic [15:0] s_output_limit = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_run_value;
    logic [7:0]  m_run_length;
    logic        m_packet_done;
    logic        m_status;
    logic [15:0] m_total_length;

    int mismatches;
    int runs_outstanding;
    int quiet_cycles  = 0;
    int bytes_sent    = 0;
    int packets_sent  = 0;
    bit quiet_tail    = 1'b0;
    bit steady_packet = 1'b0;

    logic [7:0] packet_bytes[$];

    escape_run_length_decoder_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_packet_end   (s_packet_end),
        .s_output_limit (s_output_limit),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_run_value    (m_run_value),
        .m_run_length   (m_run_length),
        .m_packet_done  (m_packet_done),
        .m_status       (m_status),
        .m_total_length (m_total_length)
    );

    erld_stream_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_packet_end     (s_packet_end),
        .s_output_limit   (s_output_limit),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_run_value      (m_run_value),
        .m_run_length     (m_run_length),
        .m_packet_done    (m_packet_done),
        .m_status         (m_status),
        .m_total_length   (m_total_length),
        .mismatches       (mismatches),
        .runs_outstanding (runs_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stop the run if neither channel completes a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The result side stalls in random bursts, and never in the tail.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    // Offer one byte, after an optional idle burst, and hold it until the transfer.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic [15:0] limit);
        int gap;
        gap = 0;
        if (!quiet_tail && !steady_packet && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 18);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= b;
        s_packet_end   <= last;
        s_output_limit <= limit;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Only the first byte carries a meaningful budget; the rest carry noise.
    task automatic send_packet(input logic [15:0] limit);
        for (int i = 0; i < packet_bytes.size(); i++)
            send_byte(packet_bytes[i], i == packet_bytes.size() - 1,
                      (i == 0) ? limit : 16'($urandom));
        packets_sent++;
    endtask

    // Hold the input off until every predicted descriptor has come out.
    task automatic wait_for_runs();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (runs_outstanding != 0) @(posedge aclk);
    endtask

    // Mostly well-formed packets; some are pure noise or end inside an escape.
    task automatic build_packet();
        int         tokens;
        logic [7:0] b;
        packet_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            tokens = $urandom_range(1, 12);
            for (int i = 0; i < tokens; i++) begin
                if ($urandom_range(0, 3) == 0)
                    b = $urandom_range(0, 1) ? ESC_LONG : ESC_ZEROS;
                else
                    b = 8'($urandom);
                packet_bytes.push_back(b);
            end
        end else begin
            tokens = $urandom_range(1, 10);
            for (int i = 0; i < tokens; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        // Any literal, skipping the two escape codes.
                        b = 8'($urandom_range(0, 253));
                        if (b == 8'd253) b = 8'hFF;
                        packet_bytes.push_back(b);
                    end
                    5, 6: packet_bytes.push_back(ESC_ZEROS);
                    default: begin
                        packet_bytes.push_back(ESC_LONG);
                        case ($urandom_range(0, 7))
                            0:       b = 8'h00;
                            1:       b = 8'hFF;
                            default: b = 8'($urandom_range(1, 12));
                        endcase
                        packet_bytes.push_back(b);
                        packet_bytes.push_back(8'($urandom));
                    end
                endcase
            end
            if ($urandom_range(0, 7) == 0) begin
                packet_bytes.push_back(ESC_LONG);
                if ($urandom_range(0, 1) == 1) packet_bytes.push_back(8'($urandom));
            end
        end
    endtask

    function automatic logic [15:0] pick_budget();
        case ($urandom_range(0, 9))
            0:             return 16'd0;
            1, 2, 3, 4, 5: return 16'($urandom_range(1, 40));
            default:       return 16'($urandom);
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Literals at both ends, both escapes, count zero and count 255.
        packet_bytes = '{8'h00, 8'hFF, ESC_ZEROS, ESC_LONG, 8'h00, 8'h55,
                         ESC_LONG, 8'hFF, 8'hAA, 8'h7F};
        send_packet(16'hFFFF);
        // A zero budget ignores the whole packet.
        packet_bytes = '{8'h12, ESC_LONG, 8'h34};
        send_packet(16'h0000);
        // The budget runs out inside a long run; the truncated escape after it is ignored.
        packet_bytes = '{8'h01, ESC_LONG, 8'h10, 8'h33, ESC_LONG};
        send_packet(16'd5);
        // Packets that end on the escape byte and on the count byte.
        packet_bytes = '{8'h41, ESC_LONG};
        send_packet(16'd100);
        packet_bytes = '{ESC_LONG, 8'h09};
        send_packet(16'd100);
        // A zero run clipped by a small budget, then a single-byte packet.
        packet_bytes = '{ESC_ZEROS, 8'h01};
        send_packet(16'd2);
        packet_bytes = '{8'h80};
        send_packet(16'd1);
        wait_for_runs();

        // Random packets; the tail runs with no idling on either side.
        while (bytes_sent < BYTE_TARGET) begin
            if (bytes_sent >= QUIET_START) quiet_tail = 1'b1;
            steady_packet = ($urandom_range(0, 4) == 0);
            build_packet();
            send_packet(pick_budget());
            if (!quiet_tail && packets_sent % 25 == 0) wait_for_runs();
        end

        wait_for_runs();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
